// ===== sv/cftp_pkg.sv =====
`timescale 1ns / 1ps
package cftp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
    localparam int NFIELDS     = 21;
    localparam int FIDX_W      = 5;
    localparam logic [FIDX_W-1:0] LAST_FIELD = FIDX_W'(NFIELDS - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // configuration register indexes
    localparam logic [2:0] REG_HEAD_FIRST  = 3'd0;
    localparam logic [2:0] REG_HEAD_SECOND = 3'd1;
    localparam logic [2:0] REG_VERSION     = 3'd2;
    localparam logic [2:0] REG_TARGET_ID   = 3'd3;
    localparam logic [2:0] REG_TARGET_LEN  = 3'd4;

    typedef enum logic [2:0] {
        K_FRAME_OK   = 3'd0,
        K_TARGET_OK  = 3'd1,
        K_VER_ERR    = 3'd2,
        K_CRC_ERR    = 3'd3,
        K_OVERSIZE   = 3'd4,
        K_TGT_LEN    = 3'd5,
        K_TGT_FIELD  = 3'd6
    } t_kind;

    // target field layout: byte offset, last byte index, signed 16-bit flag
    localparam logic [5:0] FLD_OFF [NFIELDS] = '{
        6'd0, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd14,
        6'd16, 6'd18, 6'd20, 6'd22, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd34};
    localparam logic [1:0] FLD_LASTB [NFIELDS] = '{
        2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1};
    localparam logic FLD_SGN [NFIELDS] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

    typedef struct packed {
        logic              busy;
        logic              rd_en;
        logic              acc;
        logic              emit_field;
        logic              last_field;
        logic [FIDX_W-1:0] field_idx;
        logic [1:0]        byte_idx;
    } t_cmd;

    typedef struct packed {
        logic run_start;
        logic out_free;
    } t_stat;

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ===== sv/cftp_if.sv =====
`timescale 1ns / 1ps
interface cftp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
    modport source (output valid, output rx_byte, output time_ms, input ready);
    modport sink (input valid, input rx_byte, input time_ms, output ready);
endinterface

interface cftp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface cftp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  frame_seq;
    logic [7:0]  msg_id;
    logic [31:0] end_time_ms;
    logic [4:0]  field_index;
    logic [31:0] field_value;
    logic [31:0] good_frames;
    logic [31:0] crc_fails;
    logic [31:0] ver_fails;
    logic [31:0] len_fails;
    logic [31:0] seq_gaps;
    logic        last;
    modport source (output valid, output kind, output frame_seq, output msg_id,
        output end_time_ms, output field_index, output field_value,
        output good_frames, output crc_fails, output ver_fails,
        output len_fails, output seq_gaps, output last, input ready);
    modport sink (input valid, input kind, input frame_seq, input msg_id,
        input end_time_ms, input field_index, input field_value,
        input good_frames, input crc_fails, input ver_fails,
        input len_fails, input seq_gaps, input last, output ready);
endinterface

// ===== sv/cftp_ctrl.sv =====
`timescale 1ns / 1ps
module cftp_ctrl
    import cftp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_ACC  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [FIDX_W-1:0] r_fld, n_fld;
    logic [1:0]        r_byte, n_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fld   <= '0;
            r_byte  <= '0;
        end else begin
            r_state <= n_state;
            r_fld   <= n_fld;
            r_byte  <= n_byte;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_fld            = r_fld;
        n_byte           = r_byte;
        o_cmd            = '0;
        o_cmd.field_idx  = r_fld;
        o_cmd.byte_idx   = r_byte;
        o_cmd.last_field = (r_fld == LAST_FIELD);
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.run_start) begin
                    n_state = S_RD;
                    n_fld   = '0;
                    n_byte  = '0;
                end
            end
            S_RD: begin
                o_cmd.busy  = 1'b1;
                o_cmd.rd_en = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.busy = 1'b1;
                o_cmd.acc  = 1'b1;
                if (r_byte == FLD_LASTB[r_fld]) begin
                    n_state = S_EMIT;
                end else begin
                    n_byte  = r_byte + 2'd1;
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                o_cmd.busy = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit_field = 1'b1;
                    n_byte           = '0;
                    if (r_fld == LAST_FIELD) begin
                        n_state = S_IDLE;
                    end else begin
                        n_fld   = r_fld + FIDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/cftp_dp.sv =====
`timescale 1ns / 1ps
module cftp_dp
    import cftp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cftp_in_if.sink     i_in,
    cftp_cfg_if.sink    i_cfg,
    cftp_out_if.source  o_out,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);

    typedef enum logic [8:0] {
        P_HEAD1 = 9'b000000001,
        P_HEAD2 = 9'b000000010,
        P_VER   = 9'b000000100,
        P_ID    = 9'b000001000,
        P_SEQ   = 9'b000010000,
        P_LEN   = 9'b000100000,
        P_PAY   = 9'b001000000,
        P_CRCL  = 9'b010000000,
        P_CRCH  = 9'b100000000
    } t_phase;

    logic [7:0] r_head1, r_head2, r_ver_cfg, r_tid;
    logic [6:0] r_tlen;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_ver, n_ver, r_id, n_id, r_seq, n_seq, r_crclo, n_crclo, r_prev, n_prev;
    logic [6:0]  r_len, n_len, r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic        r_seen, n_seen;
    logic [31:0] r_frames, n_frames, r_crcerr, n_crcerr, r_vererr, n_vererr;
    logic [31:0] r_lenerr, n_lenerr, r_seqlost, n_seqlost;
    logic [31:0] r_time;

    logic [7:0]  mem [MAX_PAYLOAD];
    logic [7:0]  r_rd_data;
    logic        r_rd_zero;
    logic [31:0] r_acc;

    logic        in_fire, wr_en, run_start, load, res_load;
    t_kind       res_kind;
    logic [7:0]  b;
    logic [5:0]  rd_addr;
    logic [7:0]  rd_byte;
    logic [31:0] fval;

    logic        r_ov;
    t_kind       r_kind;
    logic [7:0]  r_oseq, r_oid;
    logic [31:0] r_otime, r_oval;
    logic [4:0]  r_oidx;
    logic [31:0] r_o0, r_o1, r_o2, r_o3, r_o4;
    logic        r_olast;

    assign o_stat.out_free = !r_ov || o_out.ready;
    assign o_stat.run_start = run_start;
    assign i_in.ready = !i_cmd.busy && o_stat.out_free;
    assign i_cfg.ready = 1'b1;
    assign in_fire = i_in.valid && i_in.ready;
    assign b = i_in.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head1   <= 8'hAA;
            r_head2   <= 8'h55;
            r_ver_cfg <= 8'd1;
            r_tid     <= 8'd1;
            r_tlen    <= 7'd36;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_HEAD_FIRST:  r_head1   <= i_cfg.data;
                REG_HEAD_SECOND: r_head2   <= i_cfg.data;
                REG_VERSION:     r_ver_cfg <= i_cfg.data;
                REG_TARGET_ID:   r_tid     <= i_cfg.data;
                REG_TARGET_LEN:  r_tlen    <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_ver     = r_ver;
        n_id      = r_id;
        n_seq     = r_seq;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_crclo   = r_crclo;
        n_crc     = r_crc;
        n_prev    = r_prev;
        n_seen    = r_seen;
        n_frames  = r_frames;
        n_crcerr  = r_crcerr;
        n_vererr  = r_vererr;
        n_lenerr  = r_lenerr;
        n_seqlost = r_seqlost;
        wr_en     = 1'b0;
        run_start = 1'b0;
        res_load  = 1'b0;
        res_kind  = K_FRAME_OK;
        if (in_fire) begin
            unique case (r_phase)
                P_HEAD1: n_phase = (b == r_head1) ? P_HEAD2 : P_HEAD1;
                P_HEAD2: n_phase = (b == r_head2) ? P_VER : P_HEAD1;
                P_VER: begin
                    n_ver   = b;
                    n_crc   = crc16_step(CRC_INIT, b);
                    n_phase = P_ID;
                end
                P_ID: begin
                    n_id    = b;
                    n_crc   = crc16_step(r_crc, b);
                    n_phase = P_SEQ;
                end
                P_SEQ: begin
                    n_seq   = b;
                    n_crc   = crc16_step(r_crc, b);
                    n_phase = P_LEN;
                end
                P_LEN: begin
                    n_len = b[6:0];
                    n_cnt = '0;
                    n_crc = crc16_step(r_crc, b);
                    if (b > 8'(MAX_PAYLOAD)) begin
                        n_lenerr = r_lenerr + 32'd1;
                        n_phase  = P_HEAD1;
                        res_load = 1'b1;
                        res_kind = K_OVERSIZE;
                    end else begin
                        n_phase = (b == 8'd0) ? P_CRCL : P_PAY;
                    end
                end
                P_PAY: begin
                    wr_en = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                    n_crc = crc16_step(r_crc, b);
                    if (n_cnt >= r_len) n_phase = P_CRCL;
                end
                P_CRCL: begin
                    n_crclo = b;
                    n_phase = P_CRCH;
                end
                P_CRCH: begin
                    n_phase = P_HEAD1;
                    priority if (r_ver != r_ver_cfg) begin
                        n_vererr = r_vererr + 32'd1;
                        res_load = 1'b1;
                        res_kind = K_VER_ERR;
                    end else if (r_crc != {b, r_crclo}) begin
                        n_crcerr = r_crcerr + 32'd1;
                        res_load = 1'b1;
                        res_kind = K_CRC_ERR;
                    end else begin
                        if (r_seen && (r_prev + 8'd1) != r_seq) begin
                            n_seqlost = r_seqlost + 32'd1;
                        end
                        n_prev   = r_seq;
                        n_seen   = 1'b1;
                        n_frames = r_frames + 32'd1;
                        priority if (r_id != r_tid) begin
                            res_load = 1'b1;
                            res_kind = K_FRAME_OK;
                        end else if (r_len != r_tlen) begin
                            n_lenerr = r_lenerr + 32'd1;
                            res_load = 1'b1;
                            res_kind = K_TGT_LEN;
                        end else begin
                            run_start = 1'b1;
                        end
                    end
                end
                default: n_phase = P_HEAD1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= P_HEAD1;
            r_ver     <= '0;
            r_id      <= '0;
            r_seq     <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_crclo   <= '0;
            r_crc     <= CRC_INIT;
            r_prev    <= '0;
            r_seen    <= 1'b0;
            r_frames  <= '0;
            r_crcerr  <= '0;
            r_vererr  <= '0;
            r_lenerr  <= '0;
            r_seqlost <= '0;
        end else begin
            r_phase   <= n_phase;
            r_ver     <= n_ver;
            r_id      <= n_id;
            r_seq     <= n_seq;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_crclo   <= n_crclo;
            r_crc     <= n_crc;
            r_prev    <= n_prev;
            r_seen    <= n_seen;
            r_frames  <= n_frames;
            r_crcerr  <= n_crcerr;
            r_vererr  <= n_vererr;
            r_lenerr  <= n_lenerr;
            r_seqlost <= n_seqlost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_time <= i_in.time_ms;
    end

    // payload store and field assembly
    assign rd_addr = FLD_OFF[i_cmd.field_idx] + {4'b0, i_cmd.byte_idx};

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_cnt[PAY_AW-1:0]] <= b;
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr[PAY_AW-1:0]];
            r_rd_zero <= ({1'b0, rd_addr} >= r_len);
        end
    end

    assign rd_byte = r_rd_zero ? 8'h00 : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            unique case (i_cmd.byte_idx)
                2'd0: r_acc <= {24'h0, rd_byte};
                2'd1: r_acc[15:8] <= rd_byte;
                2'd2: r_acc[23:16] <= rd_byte;
                2'd3: r_acc[31:24] <= rd_byte;
                default: ;
            endcase
        end
    end

    assign fval = FLD_SGN[i_cmd.field_idx] ? {{16{r_acc[15]}}, r_acc[15:0]} : r_acc;

    // output register
    assign load = res_load || i_cmd.emit_field;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_kind  <= res_kind;
            r_otime <= i_in.time_ms;
            r_oidx  <= '0;
            r_oval  <= '0;
            r_olast <= 1'b1;
        end else if (i_cmd.emit_field) begin
            r_kind  <= (i_cmd.field_idx == '0) ? K_TARGET_OK : K_TGT_FIELD;
            r_otime <= r_time;
            r_oidx  <= i_cmd.field_idx;
            r_oval  <= fval;
            r_olast <= i_cmd.last_field;
        end
        if (load) begin
            r_oseq <= r_seq;
            r_oid  <= r_id;
            r_o0   <= n_frames;
            r_o1   <= n_crcerr;
            r_o2   <= n_vererr;
            r_o3   <= n_lenerr;
            r_o4   <= n_seqlost;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_kind;
    assign o_out.frame_seq   = r_oseq;
    assign o_out.msg_id      = r_oid;
    assign o_out.end_time_ms = r_otime;
    assign o_out.field_index = r_oidx;
    assign o_out.field_value = r_oval;
    assign o_out.good_frames = r_o0;
    assign o_out.crc_fails   = r_o1;
    assign o_out.ver_fails   = r_o2;
    assign o_out.len_fails   = r_o3;
    assign o_out.seq_gaps    = r_o4;
    assign o_out.last        = r_olast;

endmodule

// ===== sv/crc16_framed_target_parser.sv =====
`timescale 1ns / 1ps
// Output: a status result is loaded into the output register at the edge that takes its
// byte; a target run loads field 0 after each of its bytes is read and assembled.
// Throughput: one byte per cycle while parsing and the output register is free; a target
// frame end then emits 21 items, each field reading the store and assembling it byte by
// byte before it is loaded, while input is held.
// Reset: synchronous, active low; parser hunts the first header, counters clear.
module crc16_framed_target_parser
    import cftp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cftp_in_if.sink     i_in,
    cftp_cfg_if.sink    i_cfg,
    cftp_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    cftp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cftp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
